@@ rtl/c2s_pkg.sv @@
// Constants and the month table for the calendar to seconds converter.
`timescale 1ns / 1ps

package c2s_pkg;

  localparam int unsigned YearW    = 12;
  localparam int unsigned MonthW   = 4;
  localparam int unsigned DayW     = 5;
  localparam int unsigned HourW    = 5;
  localparam int unsigned MinuteW  = 6;
  localparam int unsigned SecondW  = 6;
  localparam int unsigned SecondsW = 32;

  localparam int unsigned CentW    = 6;   // year / 100 fits in 6 bits for 12-bit years
  localparam int unsigned DbmW     = 9;   // largest table entry is 425

  localparam logic [31:0] EpochYear   = 32'd1900;
  localparam logic [11:0] EpochYear12 = 12'd1900;
  localparam logic [11:0] LeapsTo1899 = 12'd460;   // 1899/4 - 1899/100 + 1899/400
  localparam logic [31:0] DaysPerYear = 32'd365;
  localparam logic [31:0] SecsPerDay  = 32'd86400;
  localparam logic [31:0] SecsPerHour = 32'd3600;
  localparam logic [31:0] SecsPerMin  = 32'd60;

  // floor(y / 100) == (y * Recip100) >> Recip100Sh for every 12-bit y
  localparam logic [12:0] Recip100   = 13'd5243;
  localparam int unsigned Recip100Sh = 19;
  localparam logic [6:0]  Hundred    = 7'd100;

  localparam logic [MonthW-1:0] MarchMonth = 4'd3;

  // Days in the months before month m of a common year; codes above twelve
  // keep counting 30-day months.
  function automatic logic [DbmW-1:0] days_before_month(input logic [MonthW-1:0] m);
    logic [DbmW-1:0] d;
    case (m)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd0;
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      4'd12:   d = 9'd334;
      4'd13:   d = 9'd365;
      4'd14:   d = 9'd395;
      4'd15:   d = 9'd425;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

@@ rtl/calendar_to_seconds_since_1900.sv @@
// Gregorian date and time to seconds since 1900-01-01 00:00:00, modulo 2^32.
`timescale 1ns / 1ps

// The result passes through four register ranks (A, B, C and output) after the input transfer.
// Throughput: one conversion per cycle, back to back, while the consumer keeps up.
//   A stalled output holds only the full ranks; empty ranks keep filling, so four
//   transfers can wait inside before in_ready_o drops.
// Reset: rst_ni clears all valid flags at once; payload registers are not reset.
module calendar_to_seconds_since_1900 (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [c2s_pkg::YearW-1:0]    year_i,
  input  logic [c2s_pkg::MonthW-1:0]   month_i,
  input  logic [c2s_pkg::DayW-1:0]     day_i,
  input  logic [c2s_pkg::HourW-1:0]    hour_i,
  input  logic [c2s_pkg::MinuteW-1:0]  minute_i,
  input  logic [c2s_pkg::SecondW-1:0]  second_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [c2s_pkg::SecondsW-1:0] seconds_since_1900_o
);
  import c2s_pkg::*;

  // ---------------------------------------------------------------------------
  // Pipeline control: a rank advances when it is empty or the rank after it
  // advances. The output register decouples the consumer from the next item.
  // ---------------------------------------------------------------------------
  logic va_q, vb_q, vc_q, vo_q;
  logic en_a, en_b, en_c, en_o;

  assign en_o = !vo_q || out_ready_i;
  assign en_c = !vc_q || en_o;
  assign en_b = !vb_q || en_c;
  assign en_a = !va_q || en_b;

  assign in_ready_o  = en_a;
  assign out_valid_o = vo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (en_a) va_q <= in_valid_i;
      if (en_b) vb_q <= va_q;
      if (en_c) vc_q <= vb_q;
      if (en_o) vo_q <= vc_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Rank A: capture the input transfer.
  // ---------------------------------------------------------------------------
  logic [YearW-1:0]   year_a_q;
  logic [MonthW-1:0]  month_a_q;
  logic [DayW-1:0]    day_a_q;
  logic [HourW-1:0]   hour_a_q;
  logic [MinuteW-1:0] minute_a_q;
  logic [SecondW-1:0] second_a_q;

  always_ff @(posedge clk_i) begin
    if (en_a && in_valid_i) begin
      year_a_q   <= year_i;
      month_a_q  <= month_i;
      day_a_q    <= day_i;
      hour_a_q   <= hour_i;
      minute_a_q <= minute_i;
      second_a_q <= second_i;
    end
  end

  // Century count by reciprocal multiply; exact over the whole 12-bit range.
  logic [YearW+12:0] cent_prod;
  logic [CentW-1:0]  cent_d;

  assign cent_prod = {13'd0, year_a_q} * {12'd0, Recip100};
  assign cent_d    = cent_prod[Recip100Sh +: CentW];

  // ---------------------------------------------------------------------------
  // Rank B: year, month and century count; build day count and time of day.
  // ---------------------------------------------------------------------------
  logic [YearW-1:0]   year_b_q;
  logic [MonthW-1:0]  month_b_q;
  logic [DayW-1:0]    day_b_q;
  logic [HourW-1:0]   hour_b_q;
  logic [MinuteW-1:0] minute_b_q;
  logic [SecondW-1:0] second_b_q;
  logic [CentW-1:0]   cent_b_q;

  always_ff @(posedge clk_i) begin
    if (en_b && va_q) begin
      year_b_q   <= year_a_q;
      month_b_q  <= month_a_q;
      day_b_q    <= day_a_q;
      hour_b_q   <= hour_a_q;
      minute_b_q <= minute_a_q;
      second_b_q <= second_a_q;
      cent_b_q   <= cent_d;
    end
  end

  logic [YearW-1:0] cent_x100;
  logic [YearW-1:0] rem100;
  logic             leap_yr;
  logic [YearW-1:0] leaps_thru;   // leap years in 1..year
  logic [YearW-1:0] leaps;        // leap years in 1900..year-1
  logic [31:0]      year_off;
  logic [31:0]      days_d;
  logic [31:0]      tod_d;

  assign cent_x100 = YearW'({6'd0, cent_b_q} * {5'd0, Hundred});
  assign rem100    = year_b_q - cent_x100;

  assign leap_yr = ((year_b_q[1:0] == 2'b00) && (rem100 != '0)) ||
                   ((rem100 == '0) && (cent_b_q[1:0] == 2'b00));

  assign leaps_thru = {2'b00, year_b_q[YearW-1:2]} - {6'd0, cent_b_q}
                    + {8'd0, cent_b_q[CentW-1:2]};

  // Leaps before the year: drop the year itself, then the ones up to 1899.
  assign leaps = (year_b_q > EpochYear12) ?
                 (leaps_thru - {11'd0, leap_yr} - LeapsTo1899) : '0;

  assign year_off = {20'd0, year_b_q} - EpochYear;

  assign days_d = (year_off * DaysPerYear)
                + {20'd0, leaps}
                + {23'd0, days_before_month(month_b_q)}
                + {31'd0, (month_b_q >= MarchMonth) && leap_yr};

  // Day zero wraps to minus one day; everything else adds linearly.
  assign tod_d = (({27'd0, day_b_q} - 32'd1) * SecsPerDay)
               + ({27'd0, hour_b_q} * SecsPerHour)
               + ({26'd0, minute_b_q} * SecsPerMin)
               + {26'd0, second_b_q};

  // ---------------------------------------------------------------------------
  // Rank C: day count and seconds within the day.
  // ---------------------------------------------------------------------------
  logic [31:0] days_c_q;
  logic [31:0] tod_c_q;

  always_ff @(posedge clk_i) begin
    if (en_c && vb_q) begin
      days_c_q <= days_d;
      tod_c_q  <= tod_d;
    end
  end

  logic [SecondsW-1:0] total_d;

  assign total_d = (days_c_q * SecsPerDay) + tod_c_q;

  // ---------------------------------------------------------------------------
  // Output register: hold the result until the consumer takes the transfer.
  // ---------------------------------------------------------------------------
  logic [SecondsW-1:0] total_q;

  always_ff @(posedge clk_i) begin
    if (en_o && vc_q) begin
      total_q <= total_d;
    end
  end

  assign seconds_since_1900_o = total_q;

endmodule
